[rtl/core/sample_interval_quality_monitor_top_macros.svh]
// Assertion macros for the sample interval quality monitor.
// Used by the top level; expects clk and rst in scope.
`ifndef SAMPLE_INTERVAL_QUALITY_MONITOR_TOP_MACROS_SVH
`define SAMPLE_INTERVAL_QUALITY_MONITOR_TOP_MACROS_SVH

// Same-cycle implication.
`define SQM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqm: same-cycle check failed");

// Next-cycle implication.
`define SQM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqm: next-cycle check failed");

`endif

[rtl/core/sqm_pkg.sv]
// Package for the sample interval quality monitor: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package sqm_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int TIME_BITS   = 32;
  localparam int SUM_BITS    = 48;
  localparam int DIV_BITS    = 48;
  localparam int DS_BITS     = 8;
  localparam int REF_BITS    = 28;
  localparam int RATE_BITS   = 32;
  localparam int PCT_BITS    = 7;
  localparam int PADDR_BITS  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int RECIP_BITS  = 33;
  localparam int RECIP_SHIFT = 31;

  // 1e6 us per second times 256 for Q8
  localparam logic [27:0] RATE_SCALE  = 28'd256000000;
  localparam logic [6:0]  REF_DIVISOR = 7'd100;
  // ceil(2^31 * 256 / 100): exact floor(x * 256 / 100) for x below 2^27
  localparam logic [RECIP_BITS-1:0] REF_RECIP = 33'd5497558139;

  localparam logic [2:0] ACT_SAMPLE    = 3'd0;
  localparam logic [2:0] ACT_LEFT_FIX  = 3'd1;
  localparam logic [2:0] ACT_RIGHT_FIX = 3'd2;
  localparam logic [2:0] ACT_END_DS    = 3'd3;
  localparam logic [2:0] ACT_END_TRIAL = 3'd4;

  localparam logic [1:0] REG_MIN_GAP = 2'd0;
  localparam logic [1:0] REG_MAX_GAP = 2'd1;
  localparam logic [1:0] REG_PERCENT = 2'd2;

  typedef struct packed {
    logic [2:0]           action;
    logic [TIME_BITS-1:0] timestamp_us;
  } item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] points_in_trial;
    logic [COUNT_BITS-1:0] left_fixations;
    logic [COUNT_BITS-1:0] right_fixations;
    logic [COUNT_BITS-1:0] glitch_count;
    logic [REF_BITS-1:0]   glitch_reference_q8;
    logic [RATE_BITS-1:0]  average_rate_q8;
    logic                  rate_valid;
    logic [DS_BITS-1:0]    datasets_in_trial;
  } report_t;

  typedef struct packed {
    logic [31:0]         min_gap_us;
    logic [31:0]         max_gap_us;
    logic [PCT_BITS-1:0] glitch_share;
  } cfg_t;

endpackage

[rtl/core/sqm_front.sv]
// Front end: accepts transactions, drops unknown actions, queues the rest.
// Depends on sqm_pkg.
`timescale 1ns / 1ps

module sqm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  sqm_pkg::item_t item,
  output logic          q_valid,
  input  logic          q_pop,
  output sqm_pkg::item_t q_item
);
  import sqm_pkg::*;

  item_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 known;

  assign item_stall = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign known      = (item.action inside {[ACT_SAMPLE:ACT_END_TRIAL]});
  assign push       = item_valid && !item_stall && known;
  assign q_valid    = (count != '0);
  assign q_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/sqm_div.sv]
// Restoring divider, one quotient bit per cycle, DIV_BITS quotient bits per division.
// Depends on sqm_pkg.
`timescale 1ns / 1ps

module sqm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sqm_pkg::DIV_BITS-1:0] num,
  input  logic [sqm_pkg::DIV_BITS-1:0] den,
  output logic                        done,
  output logic [sqm_pkg::DIV_BITS-1:0] quo
);
  import sqm_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] divisor;
  logic [CNT_BITS-1:0] steps;
  logic                busy;
  logic [DIV_BITS:0]   shifted;
  logic                ge;
  logic [DIV_BITS:0]   diff;

  assign shifted = {rem, quo[DIV_BITS-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= num;
      divisor <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == CNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/sqm_back.sv]
// Back end: trial state, gap accounting, end-of-trial report and output register.
// Depends on sqm_pkg and sqm_div.
`timescale 1ns / 1ps

module sqm_back (
  input  logic            clk,
  input  logic            rst,
  input  sqm_pkg::cfg_t    cfg,
  input  logic            q_valid,
  output logic            q_pop,
  input  sqm_pkg::item_t   q_item,
  output logic            report_valid,
  input  logic            report_stall,
  output sqm_pkg::report_t report
);
  import sqm_pkg::*;

  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_MUL       = 3'd1;
  localparam logic [2:0] ST_REF       = 3'd2;
  localparam logic [2:0] ST_RATE_GO   = 3'd3;
  localparam logic [2:0] ST_RATE_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT      = 3'd5;

  localparam int GAP_BITS = TIME_BITS + 1;
  localparam int IVL_BITS = COUNT_BITS + 1;
  localparam int REFP_BITS = PCT_BITS + COUNT_BITS;
  localparam int REFM_BITS = REFP_BITS + RECIP_BITS;

  logic [2:0]            state;
  logic [TIME_BITS-1:0]  prev_time;
  logic [1:0]            ds_cnt;
  logic [GAP_BITS-1:0]   pend_gap;
  logic                  pend_glitch;
  logic                  flushed;
  logic [SUM_BITS-1:0]   gap_sum;
  logic [COUNT_BITS-1:0] pts;
  logic [COUNT_BITS-1:0] lfix;
  logic [COUNT_BITS-1:0] rfix;
  logic [COUNT_BITS-1:0] glt;
  logic [DS_BITS-1:0]    dsc;

  report_t               snap;
  logic [IVL_BITS-1:0]   r_ivl;
  logic [SUM_BITS-1:0]   r_sum;
  logic                  ivl_pos;
  logic                  sum_pos;
  logic [REFP_BITS-1:0]  ref_prod;
  logic [REFM_BITS-1:0]  ref_full;
  logic [DIV_BITS-1:0]   rate_num;

  logic [TIME_BITS-1:0]  ts;
  logic [GAP_BITS-1:0]   gap;
  logic                  gap_glitch;
  logic                  flush_now;
  logic [GAP_BITS-1:0]   c_gap;
  logic                  c_glitch;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_sat;
  logic                  active;
  logic                  is_sample;
  logic [IVL_BITS-1:0]   ivl;

  logic                  div_start;
  logic [DIV_BITS-1:0]   div_num;
  logic [DIV_BITS-1:0]   div_den;
  logic                  div_done;
  logic [DIV_BITS-1:0]   div_quo;
  logic                  out_free;

  assign ts         = q_item.timestamp_us[TIME_BITS-1:0];
  assign gap        = {1'b0, ts} - {1'b0, prev_time};
  assign gap_glitch = ($signed(gap) > $signed(GAP_BITS'(cfg.max_gap_us))) ||
                      ($signed(gap) < $signed(GAP_BITS'(cfg.min_gap_us)));
  assign is_sample  = (q_item.action == ACT_SAMPLE);
  assign flush_now  = is_sample && (ds_cnt == 2'd2) && !flushed;
  assign c_gap      = flush_now ? pend_gap : gap;
  assign c_glitch   = flush_now ? pend_glitch : gap_glitch;
  assign sum_wide   = {gap_sum[SUM_BITS-1], gap_sum} +
                      {{(SUM_BITS-TIME_BITS){c_gap[GAP_BITS-1]}}, c_gap};
  assign ivl        = {1'b0, pts} - IVL_BITS'(dsc);
  assign active     = (state == ST_RUN) && q_valid;
  assign q_pop      = active && !flush_now;
  assign out_free   = !report_valid || !report_stall;
  assign ref_full   = REFM_BITS'(ref_prod) * REFM_BITS'(REF_RECIP);

  always_comb begin
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
  end

  assign div_start = (state == ST_RATE_GO);
  assign div_num   = rate_num;
  assign div_den   = r_sum;

  sqm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // report fields and division operands
  always_ff @(posedge clk) begin
    if (active && (q_item.action == ACT_END_TRIAL)) begin
      snap.points_in_trial   <= pts;
      snap.left_fixations    <= lfix;
      snap.right_fixations   <= rfix;
      snap.glitch_count      <= glt;
      snap.datasets_in_trial <= dsc;
      r_ivl                  <= ivl;
      r_sum                  <= gap_sum;
      ivl_pos                <= !ivl[IVL_BITS-1] && (ivl != '0);
      sum_pos                <= !gap_sum[SUM_BITS-1] && (gap_sum != '0);
    end
    if (state == ST_MUL) begin
      ref_prod <= REFP_BITS'(cfg.glitch_share) * REFP_BITS'(r_ivl[COUNT_BITS-1:0]);
      rate_num <= DIV_BITS'(r_ivl[COUNT_BITS-1:0]) * DIV_BITS'(RATE_SCALE);
    end
    if (state == ST_REF) begin
      if (!ivl_pos) begin
        snap.glitch_reference_q8 <= '0;
      end else if (ref_full[REFM_BITS-1:RECIP_SHIFT+REF_BITS] != '0) begin
        snap.glitch_reference_q8 <= '1;
      end else begin
        snap.glitch_reference_q8 <= ref_full[RECIP_SHIFT+REF_BITS-1:RECIP_SHIFT];
      end
    end
    if ((state == ST_RATE_WAIT) && div_done) begin
      snap.rate_valid <= ivl_pos && sum_pos;
      if (!(ivl_pos && sum_pos)) begin
        snap.average_rate_q8 <= '0;
      end else if (div_quo[DIV_BITS-1:RATE_BITS] != '0) begin
        snap.average_rate_q8 <= '1;
      end else begin
        snap.average_rate_q8 <= div_quo[RATE_BITS-1:0];
      end
    end
    if ((state == ST_EMIT) && out_free) begin
      report <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      prev_time    <= '0;
      ds_cnt       <= '0;
      pend_gap     <= '0;
      pend_glitch  <= 1'b0;
      flushed      <= 1'b0;
      gap_sum      <= '0;
      pts          <= '0;
      lfix         <= '0;
      rfix         <= '0;
      glt          <= '0;
      dsc          <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (active) begin
            case (q_item.action)
              ACT_SAMPLE: begin
                if (flush_now) begin
                  // third sample: pending first gap is committed first
                  gap_sum     <= sum_sat;
                  glt         <= (c_glitch && (glt != '1)) ? glt + 1'b1 : glt;
                  pend_gap    <= '0;
                  pend_glitch <= 1'b0;
                  flushed     <= 1'b1;
                end else begin
                  pts <= (pts != '1) ? pts + 1'b1 : pts;
                  if (ds_cnt == 2'd1) begin
                    pend_gap    <= gap;
                    pend_glitch <= gap_glitch;
                  end
                  if (ds_cnt[1]) begin
                    gap_sum <= sum_sat;
                    glt     <= (c_glitch && (glt != '1)) ? glt + 1'b1 : glt;
                  end
                  if (ds_cnt != 2'd3) begin
                    ds_cnt <= ds_cnt + 1'b1;
                  end
                  flushed   <= 1'b0;
                  prev_time <= ts;
                end
              end
              ACT_LEFT_FIX: begin
                lfix <= (lfix != '1) ? lfix + 1'b1 : lfix;
              end
              ACT_RIGHT_FIX: begin
                rfix <= (rfix != '1) ? rfix + 1'b1 : rfix;
              end
              ACT_END_DS: begin
                dsc         <= (dsc != '1) ? dsc + 1'b1 : dsc;
                ds_cnt      <= '0;
                pend_gap    <= '0;
                pend_glitch <= 1'b0;
                flushed     <= 1'b0;
              end
              ACT_END_TRIAL: begin
                prev_time   <= '0;
                ds_cnt      <= '0;
                pend_gap    <= '0;
                pend_glitch <= 1'b0;
                flushed     <= 1'b0;
                gap_sum     <= '0;
                pts         <= '0;
                lfix        <= '0;
                rfix        <= '0;
                glt         <= '0;
                dsc         <= '0;
                state       <= ST_MUL;
              end
              default: begin
                state <= ST_RUN;
              end
            endcase
          end
        end
        ST_MUL:      state <= ST_REF;
        ST_REF:      state <= ST_RATE_GO;
        ST_RATE_GO:  state <= ST_RATE_WAIT;
        ST_RATE_WAIT: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

[rtl/core/sample_interval_quality_monitor_top.sv]
// Sample interval quality monitor.
// Input channel: item_valid/item_stall/item carries one transaction: a sample
// timestamp, a left or right fixation, an end of dataset or an end of trial.
// Output channel: report_valid/report_stall/report carries one report per end
// of trial with the trial counts, glitch reference and average rate.
// APB port: min_gap_us at 0x0, max_gap_us at 0x4, allowed glitch share at 0x8.
// A four-entry queue parts the input from the trial logic; unknown actions
// are dropped there. The third sample of a dataset stays in the queue while
// the pending first gap is committed, then it is taken.
// End of trial holds the trial logic through operand products, the Q8 glitch
// reference by reciprocal multiply, a 48-step rate division on the
// one-bit-per-cycle divider, then the report register load.
// The input is accepted while a report waits; a stalled report holds, and the
// trial logic waits at the next end of trial until the report is taken.
// Reset (synchronous, active high) clears the queue, all trial counters and
// restores the register defaults.
// Depends on sqm_pkg, sqm_front, sqm_back, sqm_div and the macros header.
`timescale 1ns / 1ps
`include "sample_interval_quality_monitor_top_macros.svh"

module sample_interval_quality_monitor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  sqm_pkg::item_t                 item,
  output logic                          report_valid,
  input  logic                          report_stall,
  output sqm_pkg::report_t               report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sqm_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_gap_us   <= '0;
      cfg.max_gap_us   <= 32'd1000000;
      cfg.glitch_share <= '0;
    end else if (wr_en) begin
      case (paddr[PADDR_BITS-1:2])
        REG_MIN_GAP: cfg.min_gap_us   <= pwdata;
        REG_MAX_GAP: cfg.max_gap_us   <= pwdata;
        REG_PERCENT: cfg.glitch_share <= pwdata[PCT_BITS-1:0];
        default:     cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_BITS-1:2])
      REG_MIN_GAP: prdata = cfg.min_gap_us;
      REG_MAX_GAP: prdata = cfg.max_gap_us;
      REG_PERCENT: prdata = 32'(cfg.glitch_share);
      default:     prdata = '0;
    endcase
  end

  sqm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  sqm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

  `SQM_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid)
  `SQM_ASSERT_NOW(a_rate_zero_invalid, report_valid && !report.rate_valid, report.average_rate_q8 == '0)
  `SQM_ASSERT_NOW(a_glitch_le_points, report_valid, report.glitch_count <= report.points_in_trial)

endmodule

[test/testbench.sv]
// Testbench for sample_interval_quality_monitor_top: drives transactions and APB writes,
// predicts each end-of-trial report and checks it field by field.
// Depends on sqm_pkg and the top level RTL.
`timescale 1ns / 1ps

module testbench;
  import sqm_pkg::*;

  typedef longint unsigned u64_t;

  localparam int   HOLD_CYCLES  = 400;
  localparam int   DRAIN_CYCLES = 150;
  localparam int   PHASE_ITEMS  = 280;
  localparam u64_t COUNT_MAX    = (u64_t'(1) << COUNT_BITS) - 1;
  localparam u64_t DS_MAX       = (u64_t'(1) << DS_BITS) - 1;
  localparam u64_t REF_MAX      = (u64_t'(1) << REF_BITS) - 1;
  localparam u64_t RATE_MAX     = (u64_t'(1) << RATE_BITS) - 1;
  localparam longint GAP_SUM_MAX = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint GAP_SUM_MIN = -(longint'(1) <<< (SUM_BITS - 1));
  localparam logic [PADDR_BITS-1:0] ADDR_MIN_GAP = {REG_MIN_GAP, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_MAX_GAP = {REG_MAX_GAP, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_PERCENT = {REG_PERCENT, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  report_valid;
  logic                  report_stall;
  report_t               report;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  sample_interval_quality_monitor_top dut (.*);

  // window registers as last written
  logic [31:0]         win_min;
  logic [31:0]         win_max;
  logic [PCT_BITS-1:0] allowed_pct;

  // trial state
  logic [31:0] trial_prev_ts;
  int unsigned trial_ds_samples;
  longint      held_gap;
  bit          held_glitch;
  longint      trial_gap_sum;
  u64_t        trial_points;
  u64_t        trial_left;
  u64_t        trial_right;
  u64_t        trial_glitches;
  u64_t        trial_datasets;

  report_t     pending_reports[$];
  logic [31:0] stamp_clock;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_reports;
  int          items_sent;
  int          reports_checked;
  int          settings_used;
  int          mismatches;

  always #5 clk = ~clk;

  function automatic void clear_trial();
    trial_prev_ts    = '0;
    trial_ds_samples = 0;
    held_gap         = 0;
    held_glitch      = 1'b0;
    trial_gap_sum    = 0;
    trial_points     = 0;
    trial_left       = 0;
    trial_right      = 0;
    trial_glitches   = 0;
    trial_datasets   = 0;
  endfunction

  function automatic u64_t sat_inc(u64_t v, u64_t top);
    return (v < top) ? v + 1 : top;
  endfunction

  function automatic bit out_of_window(longint gap);
    return gap > longint'({32'd0, win_max}) || gap < longint'({32'd0, win_min});
  endfunction

  function automatic void add_gap(longint gap, bit glitch);
    longint s;
    s = trial_gap_sum + gap;
    if (s > GAP_SUM_MAX) s = GAP_SUM_MAX;
    else if (s < GAP_SUM_MIN) s = GAP_SUM_MIN;
    trial_gap_sum = s;
    if (glitch) trial_glitches = sat_inc(trial_glitches, COUNT_MAX);
  endfunction

  function automatic void take_sample(logic [31:0] ts);
    longint gap;
    gap = longint'({32'd0, ts}) - longint'({32'd0, trial_prev_ts});
    trial_points = sat_inc(trial_points, COUNT_MAX);
    if (trial_ds_samples == 1) begin
      held_gap    = gap;
      held_glitch = out_of_window(gap);
    end else if (trial_ds_samples == 2) begin
      add_gap(held_gap, held_glitch);
      held_gap    = 0;
      held_glitch = 1'b0;
      add_gap(gap, out_of_window(gap));
    end else if (trial_ds_samples >= 3) begin
      add_gap(gap, out_of_window(gap));
    end
    if (trial_ds_samples < 3) trial_ds_samples++;
    trial_prev_ts = ts;
  endfunction

  function automatic report_t close_trial();
    report_t r;
    longint  intervals;
    u64_t    ref_v;
    u64_t    rate_v;
    intervals    = longint'(trial_points) - longint'(trial_datasets);
    ref_v        = 0;
    rate_v       = 0;
    r.rate_valid = 1'b0;
    if (intervals > 0) begin
      ref_v = (u64_t'(allowed_pct) * u64_t'(intervals) * 256) / REF_DIVISOR;
      if (ref_v > REF_MAX) ref_v = REF_MAX;
      if (trial_gap_sum > 0) begin
        rate_v = (u64_t'(intervals) * RATE_SCALE) / u64_t'(trial_gap_sum);
        if (rate_v > RATE_MAX) rate_v = RATE_MAX;
        r.rate_valid = 1'b1;
      end
    end
    r.points_in_trial     = trial_points[COUNT_BITS-1:0];
    r.left_fixations      = trial_left[COUNT_BITS-1:0];
    r.right_fixations     = trial_right[COUNT_BITS-1:0];
    r.glitch_count        = trial_glitches[COUNT_BITS-1:0];
    r.glitch_reference_q8 = ref_v[REF_BITS-1:0];
    r.average_rate_q8     = rate_v[RATE_BITS-1:0];
    r.datasets_in_trial   = trial_datasets[DS_BITS-1:0];
    return r;
  endfunction

  function automatic void advance_trial(item_t it);
    case (it.action)
      ACT_SAMPLE: take_sample(it.timestamp_us);
      ACT_LEFT_FIX: trial_left = sat_inc(trial_left, COUNT_MAX);
      ACT_RIGHT_FIX: trial_right = sat_inc(trial_right, COUNT_MAX);
      ACT_END_DS: begin
        trial_datasets   = sat_inc(trial_datasets, DS_MAX);
        trial_ds_samples = 0;
        held_gap         = 0;
        held_glitch      = 1'b0;
      end
      ACT_END_TRIAL: begin
        pending_reports.push_back(close_trial());
        clear_trial();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) advance_trial(item);
  end

  function automatic void check_field(string name, u64_t expv, u64_t actv);
    if (expv !== actv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin : report_check
    report_t want;
    if (!rst && report_valid && !report_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: report with none expected", $time);
      end else begin
        want = pending_reports.pop_front();
        check_field("points_in_trial", want.points_in_trial, report.points_in_trial);
        check_field("left_fixations", want.left_fixations, report.left_fixations);
        check_field("right_fixations", want.right_fixations, report.right_fixations);
        check_field("glitch_count", want.glitch_count, report.glitch_count);
        check_field("glitch_reference_q8", want.glitch_reference_q8,
                    report.glitch_reference_q8);
        check_field("average_rate_q8", want.average_rate_q8, report.average_rate_q8);
        check_field("rate_valid", want.rate_valid, report.rate_valid);
        check_field("datasets_in_trial", want.datasets_in_trial, report.datasets_in_trial);
        reports_checked++;
      end
    end
  end

  initial begin : report_side
    int n;
    report_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reports) begin
        report_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_reports = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        report_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        report_stall <= 1'b0;
      end
    end
  end

  initial begin
    #9_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input item_t it);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.action <= ACT_END_TRIAL) items_sent++;
  endtask

  task automatic send_action(input logic [2:0] act);
    item_t it;
    it.action       = act;
    it.timestamp_us = $urandom;
    send_item(it);
  endtask

  task automatic send_sample(input logic [31:0] ts);
    item_t it;
    it.action       = ACT_SAMPLE;
    it.timestamp_us = ts;
    send_item(it);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [PCT_BITS-1:0] pct);
    settle();
    apb_write(ADDR_MIN_GAP, lo);
    win_min = lo;
    apb_write(ADDR_MAX_GAP, hi);
    win_max = hi;
    apb_write(ADDR_PERCENT, {{(32 - PCT_BITS){1'b0}}, pct});
    allowed_pct = pct;
    settings_used++;
  endtask

  function automatic logic [31:0] next_timestamp();
    u64_t lo;
    u64_t hi;
    u64_t step;
    int   pick;
    lo   = win_min;
    hi   = win_max;
    pick = $urandom_range(0, 19);
    if (pick < 13 && lo <= hi) begin
      step = lo + (u64_t'($urandom) % (hi - lo + 1));
      stamp_clock += step[31:0];
    end else if (pick < 13) begin
      stamp_clock += $urandom_range(0, 3000);
    end else if (pick < 16) begin
      case ($urandom_range(0, 3))
        0: step = lo - 1;
        1: step = lo;
        2: step = hi;
        default: step = hi + 1;
      endcase
      stamp_clock += step[31:0];
    end else if (pick < 18) begin
      stamp_clock -= $urandom_range(1, 5000);
    end else begin
      stamp_clock = $urandom;
    end
    return stamp_clock;
  endfunction

  task automatic send_noise();
    logic [2:0] act;
    do act = 3'($urandom); while (act == ACT_SAMPLE || act == ACT_END_TRIAL);
    send_action(act);
  endtask

  // well-formed trial with random content; noisy ones add stray events and open datasets
  task automatic send_trial(input int n_ds, input int max_samples, input bit noisy);
    int n;
    for (int d = 0; d < n_ds; d++) begin
      n = $urandom_range(0, max_samples);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 5) == 0)
          send_action($urandom_range(0, 1) ? ACT_LEFT_FIX : ACT_RIGHT_FIX);
        if (noisy && $urandom_range(0, 9) == 0) send_noise();
        send_sample(next_timestamp());
      end
      if (!noisy || $urandom_range(0, 5) != 0) send_action(ACT_END_DS);
    end
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_basic_trial();
    send_sample(32'd0);
    send_sample(32'd1000);
    send_action(ACT_LEFT_FIX);
    send_sample(32'd2000);
    send_action(ACT_RIGHT_FIX);
    send_sample(32'd3000);
    send_action(ACT_END_DS);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_empty_and_unknown();
    send_action(3'd5);
    send_action(3'd6);
    send_action(3'd7);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_short_and_open_datasets();
    send_sample(32'd10);
    send_sample(32'd20);
    send_action(ACT_END_DS);
    send_sample(32'd100);
    send_sample(32'd200);
    send_sample(32'd300);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_backward_time();
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
    send_sample(32'd10);
    send_action(ACT_END_DS);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_inverted_window();
    set_window(32'hFFFF_FFFF, 32'd0, 7'd127);
    send_sample(32'd500);
    send_sample(32'd600);
    send_sample(32'd700);
    send_sample(32'd800);
    send_action(ACT_END_DS);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_rate_saturation();
    set_window(32'd0, 32'hFFFF_FFFF, 7'd100);
    repeat (17) send_sample(32'd5);
    send_sample(32'd6);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_dataset_saturation();
    send_sample(32'd1);
    send_sample(32'd2);
    send_sample(32'd3);
    repeat (300) send_action(ACT_END_DS);
    send_action(ACT_END_TRIAL);
  endtask

  task automatic test_backpressure();
    settle();
    hold_reports = 1'b1;
    repeat (10) begin
      send_sample(next_timestamp());
      send_action(ACT_END_TRIAL);
    end
  endtask

  task automatic test_random_phase();
    int goal;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 19) == 0) send_trial(1, 40, 1'b0);
      else send_trial($urandom_range(1, 4), 8, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    win_min      = 32'd0;
    win_max      = 32'd1000000;
    allowed_pct  = '0;
    stamp_clock  = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_reports = 1'b0;
    clear_trial();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_trial();
    test_empty_and_unknown();
    test_short_and_open_datasets();
    test_backward_time();
    test_inverted_window();
    test_rate_saturation();
    test_dataset_saturation();
    test_backpressure();

    test_random_phase();
    set_window(32'd900, 32'd1100, 7'd5);
    test_random_phase();
    set_window(32'hFFFF_FFFF, 32'd0, 7'd127);
    test_random_phase();
    set_window(32'd0, 32'hFFFF_FFFF, 7'd100);
    test_random_phase();
    set_window(32'd1000, 32'd3000, 7'd50);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_phase();

    item_valid <= 1'b0;
    for (int i = 0; i < 100000 && pending_reports.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      mismatches++;
      $display("%0d reports never arrived", pending_reports.size());
    end

    $display("Sent %0d transactions over %0d register settings; checked %0d reports",
             items_sent, settings_used + 1, reports_checked);
    $display("including backward time, short and open datasets and a long report hold-off");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
